FILE: rtl/lru_key_value_cache_assert.svh
// assertion macros for the lru key value cache checker
// expects aclk and aresetn in the scope of each use
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LKV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lkv_pkg.sv
// shared constants, request codes and command struct of the lru key value cache
// no dependencies
package lkv_pkg;

    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int REQ_WIDTH     = 2;
    localparam int KEY_WIDTH     = 31;
    localparam int VALUE_WIDTH   = 32;
    localparam int EXT_WIDTH     = 64;
    localparam int S_TDATA_WIDTH = 64;
    localparam int M_TDATA_WIDTH = 64;
    localparam int M_TUSER_WIDTH = 2;

    localparam logic [REQ_WIDTH-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic load_req;
        logic search;
        logic commit;
    } lkv_cmd_t;

endpackage

FILE: rtl/lkv_ctrl.sv
// request sequencer of the lru key value cache: accept, search, apply
// depends on lkv_pkg
module lkv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output lkv_pkg::lkv_cmd_t cmd
);
    import lkv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_APPLY  = 3'b100
    } lkv_state_t;

    lkv_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;
    logic       accept;

    assign commit   = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (commit) begin
                    state_next = accept ? ST_SEARCH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb begin
        cmd.load_req = accept;
        cmd.search   = (state_reg == ST_SEARCH);
        cmd.commit   = commit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/lkv_datapath.sv
// slot store of the lru key value cache: key compare, age ranks, data memory, result register
// depends on lkv_pkg, driven by lkv_ctrl commands
module lkv_datapath #(
    parameter int CAPACITY   = lkv_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = lkv_pkg::DEF_DATA_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lkv_pkg::lkv_cmd_t                 cmd,
    input  logic [lkv_pkg::REQ_WIDTH-1:0]     s_tuser,
    input  logic [lkv_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    output logic [lkv_pkg::M_TUSER_WIDTH-1:0] m_tuser,
    output logic [lkv_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import lkv_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(CAPACITY - 1);

    function automatic logic [IDX_W-1:0] to_index(input logic [CAPACITY-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (vec[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    logic [REQ_WIDTH-1:0]   req_type_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    logic [CAPACITY-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]       rank_reg [CAPACITY];
    logic [IDX_W-1:0]       rank_next [CAPACITY];
    logic [KEY_WIDTH-1:0]   slot_key_reg [CAPACITY];
    logic [DATA_WIDTH-1:0]  data_mem [CAPACITY];
    logic [DATA_WIDTH-1:0]  rd_data_reg;

    logic [CAPACITY-1:0]    match_vec, free_vec, free_first, victim_vec;
    logic                   any_match, any_free;
    logic [IDX_W-1:0]       tgt_idx, victim_idx;

    logic                   hit_reg, full_reg;
    logic [IDX_W-1:0]       tgt_reg, tgt_rank_reg;
    logic [KEY_WIDTH-1:0]   evk_reg;

    logic                   is_lookup, is_insert, is_flush;
    logic                   promote_en, all_inc, evict;
    logic [EXT_WIDTH-1:0]   val_ext, rd_ext;
    logic [DATA_WIDTH-1:0]  store_val;

    logic                   out_hit_reg, out_ev_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [KEY_WIDTH-1:0]   out_evk_reg;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg <= s_tuser;
            key_reg      <= s_tdata[KEY_WIDTH-1:0];
            value_reg    <= s_tdata[KEY_WIDTH +: VALUE_WIDTH];
        end
    end

    // parallel key compare and slot selection
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i]  = valid_reg[i] && (slot_key_reg[i] == key_reg);
            free_vec[i]   = !valid_reg[i];
            victim_vec[i] = (rank_reg[i] == RANK_MAX);
        end
        free_first = free_vec & (~free_vec + CAPACITY'(1));
        any_match  = |match_vec;
        any_free   = |free_vec;
        victim_idx = to_index(victim_vec);
        if (any_match) begin
            tgt_idx = to_index(match_vec);
        end else if (any_free) begin
            tgt_idx = to_index(free_first);
        end else begin
            tgt_idx = victim_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            hit_reg      <= any_match;
            full_reg     <= !any_free;
            tgt_reg      <= tgt_idx;
            tgt_rank_reg <= rank_reg[tgt_idx];
            evk_reg      <= slot_key_reg[victim_idx];
        end
    end

    assign is_lookup  = (req_type_reg == REQ_LOOKUP);
    assign is_insert  = (req_type_reg == REQ_INSERT);
    assign is_flush   = (req_type_reg == REQ_FLUSH);
    assign promote_en = cmd.commit && ((is_lookup && hit_reg) || is_insert);
    assign all_inc    = !hit_reg && !full_reg;
    assign evict      = is_insert && !hit_reg && full_reg;

    // valid marks and age ranks
    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit && is_flush) begin
            valid_next = '0;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_next[i] = '0;
            end
        end else if (promote_en) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (IDX_W'(i) == tgt_reg) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (all_inc || (rank_reg[i] < tgt_rank_reg))) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            valid_next[tgt_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // keys and data
    assign val_ext   = EXT_WIDTH'(value_reg);
    assign store_val = val_ext[DATA_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.commit && is_insert) begin
            slot_key_reg[tgt_reg] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && is_insert) begin
            data_mem[tgt_reg] <= store_val;
        end
        if (cmd.search) begin
            rd_data_reg <= data_mem[tgt_idx];
        end
    end

    always_comb begin
        rd_ext = '0;
        rd_ext[DATA_WIDTH-1:0] = rd_data_reg;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg   <= hit_reg && (is_lookup || is_insert);
            out_value_reg <= (is_lookup && hit_reg) ? rd_ext[VALUE_WIDTH-1:0] : '0;
            out_ev_reg    <= evict;
            out_evk_reg   <= evict ? evk_reg : '0;
        end
    end

    assign m_tdata = {1'b0, out_evk_reg, out_value_reg};
    assign m_tuser = {out_ev_reg, out_hit_reg};

endmodule

FILE: rtl/lru_key_value_cache.sv
// top level of the lru key value cache: sequencer plus slot datapath
// depends on lkv_pkg, lkv_ctrl, lkv_datapath
//
// Fully associative key to data cache with least-recently-used replacement.
// Requests come in on the s_ stream: s_tuser is the request type (lookup,
// insert or update, flush), s_tdata carries key and insert data. Every
// request gives exactly one result on the m_ stream: hit and eviction flags
// in m_tuser, lookup data and evicted key in m_tdata.
// A request is accepted, compared against all slots in the next cycle and
// then applied once the output register is free or being read; the result
// is registered at the apply step. A new request is taken in the cycle its
// predecessor is applied, so each request is searched and then applied over
// the slot registers before the next one is searched.
// The result sits in an output register; while m_tready is low the next
// request is still accepted and searched, and it waits to be applied until
// the output register frees.
// Reset clears all valid marks and age ranks at once; the cache is empty and
// ready in the first cycle after reset.
module lru_key_value_cache #(
    parameter int CAPACITY   = lkv_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = lkv_pkg::DEF_DATA_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lkv_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // key, entry_value, zero pad
    input  logic [lkv_pkg::REQ_WIDTH-1:0]     s_tuser,  // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lkv_pkg::M_TDATA_WIDTH-1:0] m_tdata,  // value_out, evicted_key, zero pad
    output logic [lkv_pkg::M_TUSER_WIDTH-1:0] m_tuser   // hit, evicted_valid
);
    import lkv_pkg::*;

    lkv_cmd_t cmd;

    lkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lkv_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

endmodule

FILE: rtl/lkv_checker.sv
// port-level checks of the lru key value cache, bound to the top level
// depends on lkv_pkg and lru_key_value_cache_assert.svh
`include "lru_key_value_cache_assert.svh"

module lkv_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lkv_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input logic [lkv_pkg::M_TUSER_WIDTH-1:0] m_tuser
);
    import lkv_pkg::*;

    // stalled result holds
    `LKV_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // an accepted request is searched before the next one is taken
    `LKV_ASSERT_NEXT(a_one_in_search, s_tvalid && s_tready, !s_tready,
        "request accepted during search")

    // a hit never evicts
    `LKV_ASSERT_IMP(a_hit_no_evict, m_tvalid, !(m_tuser[0] && m_tuser[1]),
        "hit and eviction together")

    // evicted key is zero unless an eviction is flagged
    `LKV_ASSERT_IMP(a_evk_zero, m_tvalid && !m_tuser[1],
        m_tdata[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH] == '0, "evicted key without eviction")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/lru_key_value_cache_checker.sv
// result checker for the lru key value cache: watches both stream channels,
// predicts every result and compares it field by field
// depends on lkv_pkg
`timescale 1ns / 1ps

module lru_key_value_cache_checker #(
    parameter int CAPACITY = lkv_pkg::DEF_CAPACITY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [lkv_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    input  logic [lkv_pkg::REQ_WIDTH-1:0]     s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lkv_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input  logic [lkv_pkg::M_TUSER_WIDTH-1:0] m_tuser,
    output int                                mismatches,
    output int                                pending,
    output int                                results_seen,
    output int                                hits_seen,
    output int                                evictions_seen
);
    import lkv_pkg::*;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] data_out;
        logic                   evicted;
        logic [KEY_WIDTH-1:0]   evicted_key;
    } cache_result_t;

    logic                   slot_valid [CAPACITY];
    logic [KEY_WIDTH-1:0]   slot_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] slot_data  [CAPACITY];
    int                     slot_rank  [CAPACITY];

    cache_result_t expected_q[$];

    function automatic int find_slot(logic [KEY_WIDTH-1:0] k);
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    // younger valid slots age by one, slot s becomes newest
    function automatic void make_newest(int s);
        int r;
        r = slot_rank[s];
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void clear_cache();
        for (int i = 0; i < CAPACITY; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end
    endfunction

    function automatic cache_result_t apply_request(logic [REQ_WIDTH-1:0] req,
                                                    logic [KEY_WIDTH-1:0] k,
                                                    logic [VALUE_WIDTH-1:0] v);
        cache_result_t res;
        int s;
        int victim;
        res = '0;
        s = find_slot(k);
        case (req)
            REQ_LOOKUP: begin
                if (s >= 0) begin
                    res.hit = 1'b1;
                    res.data_out = slot_data[s];
                    make_newest(s);
                end
            end
            REQ_INSERT: begin
                if (s >= 0) begin
                    res.hit = 1'b1;
                    slot_data[s] = v;
                    make_newest(s);
                end else begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (!slot_valid[i]) begin
                            s = i;
                            break;
                        end
                    if (s >= 0) begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (slot_valid[i])
                                slot_rank[i]++;
                        slot_valid[s] = 1'b1;
                        slot_key[s]   = k;
                        slot_data[s]  = v;
                        slot_rank[s]  = 0;
                    end else begin
                        // full: replace the oldest, lowest index on a tie
                        victim = 0;
                        for (int i = 1; i < CAPACITY; i++)
                            if (slot_rank[i] > slot_rank[victim])
                                victim = i;
                        res.evicted = 1'b1;
                        res.evicted_key = slot_key[victim];
                        slot_key[victim]  = k;
                        slot_data[victim] = v;
                        make_newest(victim);
                    end
                end
            end
            REQ_FLUSH: clear_cache();
            default: ;
        endcase
        return res;
    endfunction

    function automatic void report(string what, cache_result_t want, cache_result_t got);
        if (mismatches <= 10)
            $display("%s at result %0d: expected hit=%0b data=%h evict=%0b key=%h,",
                     what, results_seen, want.hit, want.data_out, want.evicted,
                     want.evicted_key, " got hit=%0b data=%h evict=%0b key=%h",
                     got.hit, got.data_out, got.evicted, got.evicted_key);
    endfunction

    always @(posedge aclk) begin
        cache_result_t got;
        cache_result_t want;
        if (!aresetn) begin
            clear_cache();
            expected_q.delete();
            mismatches     = 0;
            results_seen   = 0;
            hits_seen      = 0;
            evictions_seen = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tuser, s_tdata[KEY_WIDTH-1:0],
                                     s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH]));
            if (m_tvalid && m_tready) begin
                got.hit         = m_tuser[0];
                got.evicted     = m_tuser[1];
                got.data_out    = m_tdata[VALUE_WIDTH-1:0];
                got.evicted_key = m_tdata[VALUE_WIDTH+KEY_WIDTH-1:VALUE_WIDTH];
                if (expected_q.size() == 0) begin
                    mismatches++;
                    report("unexpected result", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.hit != want.hit || got.data_out != want.data_out ||
                        got.evicted != want.evicted || got.evicted_key != want.evicted_key) begin
                        mismatches++;
                        report("mismatch", want, got);
                    end
                    hits_seen      += want.hit;
                    evictions_seen += want.evicted;
                end
                results_seen++;
            end
        end
        pending <= expected_q.size();
    end

endmodule

FILE: bench/lru_key_value_cache_tb.sv
// top of the lru key value cache testbench: clock, reset, request stimulus,
// result back pressure and the verdict
// depends on lkv_pkg, lru_key_value_cache and lru_key_value_cache_checker
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam logic [REQ_WIDTH-1:0] REQ_RESERVED = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int POOL_DEPTH  = 64;
    localparam int PHASE_ITEMS = 285;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata  = '0;
    logic [REQ_WIDTH-1:0]     s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic [M_TUSER_WIDTH-1:0] m_tuser;

    int mismatches;
    int pending;
    int results_seen;
    int hits_seen;
    int evictions_seen;

    int  requests_sent;
    int  sent_by_type [4];
    int  burst_left;
    int  idle_cycles;
    bit  hold_req;
    logic [KEY_WIDTH-1:0] key_pool [POOL_DEPTH];

    always #10 aclk = ~aclk;

    lru_key_value_cache dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lru_key_value_cache_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    // one request, preceded by a random gap when the current burst is used up
    task automatic send_req(input logic [REQ_WIDTH-1:0] req, input logic [KEY_WIDTH-1:0] k,
                            input logic [VALUE_WIDTH-1:0] v);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, v, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        sent_by_type[req]++;
    endtask

    task automatic send_random(input int pool_size);
        logic [REQ_WIDTH-1:0]   req;
        logic [KEY_WIDTH-1:0]   k;
        logic [VALUE_WIDTH-1:0] v;
        int r;
        r = $urandom_range(0, 199);
        if (r < 100)
            req = REQ_LOOKUP;
        else if (r < 194)
            req = REQ_INSERT;
        else if (r < 198)
            req = REQ_RESERVED;
        else
            req = REQ_FLUSH;
        if ($urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, pool_size - 1)];
        else
            k = KEY_WIDTH'($urandom);
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
        endcase
        send_req(req, k, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // result side: stall patterns of its own, plus one long hold on request
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int pool_sizes [4];
        pool_sizes = '{16, 40, 64, 33};
        requests_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_DEPTH; i++)
            key_pool[i] = KEY_WIDTH'($urandom);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cache, key and data extremes, update, flush, reserved type
        send_req(REQ_LOOKUP,   31'd0,          32'hFFFF_FFFF);
        send_req(REQ_INSERT,   31'd0,          32'h0000_0000);
        send_req(REQ_INSERT,   31'h7FFF_FFFF,  32'hFFFF_FFFF);
        send_req(REQ_LOOKUP,   31'h7FFF_FFFF,  32'h0000_0000);
        send_req(REQ_LOOKUP,   31'd0,          32'h1234_5678);
        send_req(REQ_INSERT,   31'd0,          32'hA5A5_A5A5);
        send_req(REQ_LOOKUP,   31'd0,          32'h0000_0000);
        send_req(REQ_LOOKUP,   31'h2AAA_AAAA,  32'h0000_0000);
        send_req(REQ_INSERT,   31'h5555_5555,  32'h5A5A_5A5A);
        send_req(REQ_RESERVED, 31'd0,          32'hFFFF_FFFF);
        send_req(REQ_LOOKUP,   31'd0,          32'hFFFF_FFFF);
        send_req(REQ_LOOKUP,   31'h5555_5555,  32'h0000_0000);
        send_req(REQ_FLUSH,    31'h7FFF_FFFF,  32'hFFFF_FFFF);
        send_req(REQ_LOOKUP,   31'd0,          32'h0000_0000);
        send_req(REQ_LOOKUP,   31'h7FFF_FFFF,  32'h0000_0000);
        send_req(REQ_INSERT,   31'h7FFF_FFFF,  32'h8000_0001);
        send_req(REQ_LOOKUP,   31'h7FFF_FFFF,  32'h0000_0000);
        drain();

        // random phases with key pools below, near and above capacity
        for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 100)
                    hold_req = 1'b1;
                send_random(pool_sizes[p]);
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("%0d requests (%0d lookups, %0d inserts, %0d flushes, %0d reserved)",
                 requests_sent, sent_by_type[REQ_LOOKUP], sent_by_type[REQ_INSERT],
                 sent_by_type[REQ_FLUSH], sent_by_type[REQ_RESERVED]);
        $display("%0d results checked, %0d hits, %0d evictions, %0d mismatches",
                 results_seen, hits_seen, evictions_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: lru_key_value_cache.f
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_ctrl.sv
rtl/lkv_datapath.sv
rtl/lru_key_value_cache.sv
rtl/lkv_checker.sv
bench/lru_key_value_cache_checker.sv
bench/lru_key_value_cache_tb.sv
